FILE: hw/rtl/vlrs_pkg.sv
// Package for the variable length record stack.
// Holds field widths, operation codes, transaction payload types and defaults.
// No dependencies.
`default_nettype none

package vlrs_pkg;

	localparam int DATA_W = 8;
	localparam int LEN_W = 10;
	localparam int WANT_W = 6;
	localparam int FREE_W = 11;
	localparam int MAX_COPY = 63;

	localparam int STORE_BYTES_DEF = 1024;
	localparam int HEADER_BYTES_DEF = 2;

	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_POP   = 2'd1,
		FUNC_PEEK  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef struct packed {
		func_t               func;
		logic [DATA_W-1:0]   data_byte;
		logic [LEN_W-1:0]    elem_len;
		logic [WANT_W-1:0]   want_len;
	} cmd_item_t;

	typedef struct packed {
		logic                ok;
		logic                byte_valid;
		logic [DATA_W-1:0]   data_out;
		logic                last;
		logic                empty_res;
		logic [FREE_W-1:0]   free_bytes;
	} rsp_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR_WR,
		ST_HDR_RD,
		ST_HDR_LAST,
		ST_CLAMP,
		ST_SETUP,
		ST_BYTE_RD,
		ST_BYTE_OUT
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vlrs_if.sv
// Valid/ready channel interfaces for the record stack command and response.
// Depends on vlrs_pkg for the payload types.
`default_nettype none

interface vlrs_cmd_if;
	import vlrs_pkg::*;
	logic      valid;
	logic      ready;
	cmd_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vlrs_rsp_if;
	import vlrs_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/vlrs_ram.sv
// Byte store of the record stack: one write port, one read port, registered read.
// No package dependencies.
`default_nettype none

module vlrs_ram #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/vlrs_ctrl.sv
// Sequencer of the record stack: push streaming, header write and read,
// byte walk-out and the response register. Depends on vlrs_pkg and vlrs_if.
`default_nettype none

module vlrs_ctrl import vlrs_pkg::*; #(
	parameter int STORE_BYTES = STORE_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int AW = $clog2(STORE_BYTES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	vlrs_cmd_if.sink           cmd,
	vlrs_rsp_if.source         rsp,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [7:0]         mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  wire logic [7:0]    mem_rdata
);

	localparam int TW = $clog2(STORE_BYTES + 1);
	localparam int PW = ((TW > LEN_W) ? TW : LEN_W) + 1;
	localparam int SW = 8 * HEADER_BYTES;
	localparam int CMPW = (SW > TW) ? SW : TW;
	localparam int NMW = (TW > WANT_W) ? TW : WANT_W;
	localparam int HIW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

	state_t            state_q, state_n;
	logic [TW-1:0]     top_q, top_n;
	logic [LEN_W-1:0]  rcv_q, rcv_n;
	logic              refuse_q, refuse_n;
	logic              ov_q, ov_n;
	logic              hv_s1;
	logic [HIW-1:0]    hidx_s1;

	logic [LEN_W-1:0]  len_q, len_n;
	logic [AW-1:0]     hbase_q, hbase_n;
	logic [HIW-1:0]    hidx_q, hidx_n;
	logic [TW-1:0]     below_q, below_n;
	logic [WANT_W-1:0] want_q, want_n;
	logic              pop_q, pop_n;
	logic [SW-1:0]     stored_q, stored_n;
	logic [TW-1:0]     clamp_q, clamp_n;
	logic [TW-1:0]     start_q, start_n;
	logic [WANT_W-1:0] n_q, n_n;
	logic [WANT_W-1:0] k_q, k_n;
	rsp_item_t         out_q, out_n;

	logic              out_free;
	logic              cmd_ready;
	logic              load;
	logic              res_ok;
	logic              res_bv;
	logic [7:0]        res_data;
	logic              res_last;
	logic              first;
	logic [LEN_W-1:0]  plen;
	logic              pref;
	logic              fits;
	logic              over;
	logic [TW-1:0]     free_now;
	logic [LEN_W-1:0]  rcv_inc;
	logic [WANT_W-1:0] nv;

	assign out_free = !ov_q || rsp.ready;
	assign cmd_ready = (state_q == ST_IDLE) && out_free;
	assign cmd.ready = cmd_ready;
	assign rsp.valid = ov_q;
	assign rsp.data = out_q;

	assign free_now = TW'(STORE_BYTES) - top_q;
	assign fits = (LEN_W'(cmd.data.elem_len >> (8 * HEADER_BYTES))) == '0;
	assign over = (PW'(HEADER_BYTES) + PW'(cmd.data.elem_len)) > PW'(free_now);
	assign first = (rcv_q == '0);
	assign plen = first ? cmd.data.elem_len : len_q;
	assign pref = first ? (!fits || over) : refuse_q;
	assign rcv_inc = rcv_q + LEN_W'(1);

	always_comb begin
		state_n = state_q;
		top_n = top_q;
		rcv_n = rcv_q;
		refuse_n = refuse_q;
		len_n = len_q;
		hbase_n = hbase_q;
		hidx_n = hidx_q;
		below_n = below_q;
		want_n = want_q;
		pop_n = pop_q;
		stored_n = stored_q;
		clamp_n = clamp_q;
		start_n = start_q;
		n_n = n_q;
		k_n = k_q;
		nv = '0;
		load = 1'b0;
		res_ok = 1'b1;
		res_bv = 1'b0;
		res_data = '0;
		res_last = 1'b1;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = '0;

		if (hv_s1) begin
			stored_n = stored_q | (SW'(mem_rdata) << (8 * hidx_s1));
		end

		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid && cmd_ready) begin
					if (cmd.data.func == FUNC_PUSH) begin
						if (plen != '0 && !pref) begin
							mem_we = 1'b1;
							mem_waddr = AW'(PW'(top_q) + PW'(rcv_q));
							mem_wdata = cmd.data.data_byte;
						end
						if (plen != '0 && rcv_inc < plen) begin
							rcv_n = rcv_inc;
							len_n = plen;
							refuse_n = pref;
						end else begin
							rcv_n = '0;
							refuse_n = 1'b0;
							load = 1'b1;
							if (pref) begin
								res_ok = 1'b0;
							end else begin
								top_n = TW'(PW'(top_q) + PW'(plen) + PW'(HEADER_BYTES));
								hbase_n = AW'(PW'(top_q) + PW'(plen));
								len_n = plen;
								hidx_n = '0;
								state_n = ST_HDR_WR;
							end
						end
					end else begin
						rcv_n = '0;
						refuse_n = 1'b0;
						if (cmd.data.func == FUNC_CLEAR) begin
							top_n = '0;
							load = 1'b1;
						end else if (top_q == '0) begin
							load = 1'b1;
							res_ok = 1'b0;
						end else begin
							below_n = (top_q >= TW'(HEADER_BYTES)) ?
								top_q - TW'(HEADER_BYTES) : '0;
							want_n = cmd.data.want_len;
							pop_n = (cmd.data.func == FUNC_POP);
							stored_n = '0;
							hidx_n = '0;
							state_n = ST_HDR_RD;
						end
					end
				end
			end
			ST_HDR_WR: begin
				mem_we = 1'b1;
				mem_waddr = hbase_q + AW'(hidx_q);
				mem_wdata = 8'(len_q >> (8 * hidx_q));
				if (hidx_q == HIW'(HEADER_BYTES - 1)) begin
					state_n = ST_IDLE;
				end else begin
					hidx_n = hidx_q + HIW'(1);
				end
			end
			ST_HDR_RD: begin
				mem_re = 1'b1;
				mem_raddr = AW'(below_q + TW'(hidx_q));
				if (hidx_q == HIW'(HEADER_BYTES - 1)) begin
					state_n = ST_HDR_LAST;
				end else begin
					hidx_n = hidx_q + HIW'(1);
				end
			end
			ST_HDR_LAST: begin
				state_n = ST_CLAMP;
			end
			ST_CLAMP: begin
				clamp_n = (CMPW'(stored_q) > CMPW'(below_q)) ? below_q : TW'(stored_q);
				state_n = ST_SETUP;
			end
			ST_SETUP: begin
				start_n = below_q - clamp_q;
				nv = (NMW'(clamp_q) < NMW'(want_q)) ? WANT_W'(clamp_q) : want_q;
				if (nv > WANT_W'(MAX_COPY)) begin
					nv = WANT_W'(MAX_COPY);
				end
				if (pop_q) begin
					top_n = start_n;
				end
				if (nv == '0) begin
					load = 1'b1;
					state_n = ST_IDLE;
				end else begin
					n_n = nv;
					k_n = '0;
					state_n = ST_BYTE_RD;
				end
			end
			ST_BYTE_RD: begin
				mem_re = 1'b1;
				mem_raddr = AW'(start_q + TW'(k_q));
				state_n = ST_BYTE_OUT;
			end
			ST_BYTE_OUT: begin
				if (out_free) begin
					load = 1'b1;
					res_bv = 1'b1;
					res_data = mem_rdata;
					res_last = ((k_q + WANT_W'(1)) == n_q);
					k_n = k_q + WANT_W'(1);
					state_n = res_last ? ST_IDLE : ST_BYTE_RD;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase

		out_n.ok = res_ok;
		out_n.byte_valid = res_bv;
		out_n.data_out = res_data;
		out_n.last = res_last;
		out_n.empty_res = (top_n == '0);
		out_n.free_bytes = FREE_W'(TW'(STORE_BYTES) - top_n);

		if (load) begin
			ov_n = 1'b1;
		end else if (rsp.ready) begin
			ov_n = 1'b0;
		end else begin
			ov_n = ov_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			top_q <= '0;
			rcv_q <= '0;
			refuse_q <= 1'b0;
			ov_q <= 1'b0;
			hv_s1 <= 1'b0;
		end else begin
			state_q <= state_n;
			top_q <= top_n;
			rcv_q <= rcv_n;
			refuse_q <= refuse_n;
			ov_q <= ov_n;
			hv_s1 <= (state_q == ST_HDR_RD);
		end
	end

	always_ff @(posedge clk) begin
		hidx_s1 <= hidx_q;
		len_q <= len_n;
		hbase_q <= hbase_n;
		hidx_q <= hidx_n;
		below_q <= below_n;
		want_q <= want_n;
		pop_q <= pop_n;
		stored_q <= stored_n;
		clamp_q <= clamp_n;
		start_q <= start_n;
		n_q <= n_n;
		k_q <= k_n;
		if (load) begin
			out_q <= out_n;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/variable_length_record_stack_top.sv
// Push: one byte transaction per cycle while the response register is free; the final
// byte's response is valid the next cycle, then header writes on the single write port.
// Pop/peek: header reads, read settle, clamp and setup, then for each returned byte a
// byte read and a byte load that waits for a free response register; no new command is
// taken until the last byte is out. With nothing to return the response loads in setup.
// Reset: asynchronous, clears the stack pointer and push state; the byte store
// keeps its contents and needs no clearing pass.
`default_nettype none

module variable_length_record_stack_top import vlrs_pkg::*; #(
	parameter int STORE_BYTES = STORE_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	vlrs_cmd_if.sink   cmd,
	vlrs_rsp_if.source rsp
);

	localparam int AW = $clog2(STORE_BYTES);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	vlrs_ram #(
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	vlrs_ctrl #(
		.STORE_BYTES  (STORE_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.AW           (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> (!rsp.valid || rsp.ready))
		else $error("command taken while response register is blocked");

	a_byte_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.byte_valid) |-> rsp.data.ok)
		else $error("returned byte on a failed transaction");

	a_empty_all_free: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.empty_res) |->
			(rsp.data.free_bytes == FREE_W'(STORE_BYTES)))
		else $error("empty stack reports used bytes");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (32'(mem_waddr) < STORE_BYTES))
		else $error("byte store write beyond depth");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for variable_length_record_stack_top: a queue-fed command driver, a response
// monitor and a behavioral record stack that predicts every response transaction.
// Depends on vlrs_pkg, the vlrs_cmd_if / vlrs_rsp_if interfaces and the top-level RTL.

module testbench;
	import vlrs_pkg::*;

	localparam int STORE = STORE_BYTES_DEF;
	localparam int HDR = HEADER_BYTES_DEF;
	localparam int IDLE_PCT = 24;
	localparam int RANDOM_ITEMS = 248;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;

	vlrs_cmd_if cmd_ch();
	vlrs_rsp_if rsp_ch();

	variable_length_record_stack_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	logic [7:0]  store_img [STORE];
	int unsigned top_ptr = 0;
	int unsigned got_bytes = 0;
	int unsigned rec_len = 0;
	bit          rec_refused = 1'b0;

	cmd_item_t   backlog [$];
	rsp_item_t   replies [$];
	rsp_item_t   reply_head;
	int unsigned planned_cnt = 0;
	int unsigned sent_cnt = 0;
	int unsigned random_start = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int          mismatches = 0;
	wire         calm = sent_cnt >= random_start + 60 && sent_cnt < random_start + 200;

	function automatic void queue_reply(bit ok, bit bv, logic [7:0] d, bit fin);
		rsp_item_t r;
		r.ok = ok;
		r.byte_valid = bv;
		r.data_out = d;
		r.last = fin;
		r.empty_res = (top_ptr == 0);
		r.free_bytes = FREE_W'(STORE - top_ptr);
		replies.push_back(r);
	endfunction

	function automatic void stack_apply(cmd_item_t c);
		int unsigned below;
		int unsigned stored;
		int unsigned start;
		int unsigned n;
		if (c.func == FUNC_PUSH) begin
			if (got_bytes == 0) begin
				rec_len = c.elem_len;
				rec_refused = (HDR < 4 && (rec_len >> (8 * HDR)) != 0) ||
					HDR + rec_len > STORE - top_ptr;
			end
			if (rec_len != 0) begin
				if (!rec_refused && top_ptr + got_bytes < STORE)
					store_img[top_ptr + got_bytes] = c.data_byte;
				got_bytes++;
				if (got_bytes < rec_len)
					return;
			end
			got_bytes = 0;
			if (rec_refused) begin
				rec_refused = 1'b0;
				queue_reply(1'b0, 1'b0, 8'h00, 1'b1);
				return;
			end
			top_ptr += rec_len;
			for (int i = 0; i < HDR; i++)
				if (top_ptr + i < STORE)
					store_img[top_ptr + i] = (i < 4) ? 8'(rec_len >> (8 * i)) : 8'h00;
			top_ptr += HDR;
			queue_reply(1'b1, 1'b0, 8'h00, 1'b1);
			return;
		end
		// drop any unfinished record
		got_bytes = 0;
		rec_refused = 1'b0;
		if (c.func == FUNC_CLEAR) begin
			top_ptr = 0;
			queue_reply(1'b1, 1'b0, 8'h00, 1'b1);
			return;
		end
		if (top_ptr == 0) begin
			queue_reply(1'b0, 1'b0, 8'h00, 1'b1);
			return;
		end
		below = (top_ptr >= HDR) ? top_ptr - HDR : 0;
		stored = 0;
		for (int i = 0; i < HDR; i++)
			stored |= int'(store_img[below + i]) << (8 * i);
		if (stored > below)
			stored = below;
		start = below - stored;
		n = stored;
		if (n > c.want_len)
			n = c.want_len;
		if (n > MAX_COPY)
			n = MAX_COPY;
		if (c.func == FUNC_POP)
			top_ptr = start;
		if (n == 0)
			queue_reply(1'b1, 1'b0, 8'h00, 1'b1);
		else
			for (int k = 0; k < n; k++)
				queue_reply(1'b1, 1'b1, store_img[start + k], k + 1 == n);
	endfunction

	function automatic void check_field(string name, logic [FREE_W-1:0] want,
		logic [FREE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void add_cmd(func_t f, int b, int len, int want);
		cmd_item_t c;
		c.func = f;
		c.data_byte = DATA_W'(b);
		c.elem_len = LEN_W'(len);
		c.want_len = WANT_W'(want);
		backlog.push_back(c);
	endfunction

	function automatic void add_op(func_t f, int want);
		add_cmd(f, $urandom_range(0, 255), $urandom_range(0, 1022), want);
	endfunction

	// stream a record, stopping after at most stop byte transactions
	function automatic void add_record(int len, int stop);
		int items;
		items = (len == 0) ? 1 : len;
		if (items > stop)
			items = stop;
		for (int k = 0; k < items; k++)
			add_cmd(FUNC_PUSH, $urandom_range(0, 255),
				(k == 0) ? len : $urandom_range(0, 1022), $urandom_range(0, 63));
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int pick;
		int len;
		int span;
		foreach (store_img[i])
			store_img[i] = 8'h00;

		add_cmd(FUNC_POP, 8'h00, 0, 63);
		add_cmd(FUNC_PEEK, 8'hFF, 1022, 0);
		add_cmd(FUNC_PUSH, 8'hFF, 0, 63);
		add_cmd(FUNC_PEEK, 8'h00, 0, 63);
		add_cmd(FUNC_PUSH, 8'h00, 3, 0);
		add_cmd(FUNC_PUSH, 8'hFF, 1022, 63);
		add_cmd(FUNC_PUSH, 8'hA5, 0, 0);
		add_cmd(FUNC_PEEK, 8'h5A, 1, 2);
		add_cmd(FUNC_PEEK, 8'h5A, 1, 0);
		add_cmd(FUNC_POP, 8'h00, 0, 63);
		add_cmd(FUNC_POP, 8'h00, 0, 5);
		add_cmd(FUNC_PUSH, 8'h11, 4, 0);
		add_cmd(FUNC_PUSH, 8'h22, 0, 0);
		add_cmd(FUNC_CLEAR, 8'h00, 0, 0);
		add_cmd(FUNC_PUSH, 8'h33, 2, 9);
		add_cmd(FUNC_POP, 8'h00, 0, 7);
		add_cmd(FUNC_PUSH, 8'h44, 1, 0);
		add_cmd(FUNC_PUSH, 8'h55, 1, 0);
		add_cmd(FUNC_PEEK, 8'h00, 0, 63);
		add_cmd(FUNC_CLEAR, 8'hFF, 1022, 63);
		add_cmd(FUNC_PUSH, 8'h66, 1022, 0);
		add_cmd(FUNC_PEEK, 8'h00, 0, 63);
		random_start = backlog.size();

		while (backlog.size() < random_start + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				span = $urandom_range(0, 99);
				if (span < 60)
					len = $urandom_range(0, 6);
				else if (span < 90)
					len = $urandom_range(7, 40);
				else
					len = $urandom_range(41, 130);
				add_record(len, 1024);
			end else if (pick < 58) begin
				len = $urandom_range(2, 1022);
				add_record(len, $urandom_range(1, (len - 1 < 6) ? len - 1 : 6));
				add_op(func_t'($urandom_range(1, 3)), $urandom_range(0, 63));
			end else if (pick < 78) begin
				add_op(FUNC_POP, $urandom_range(0, 63));
			end else if (pick < 95) begin
				add_op(FUNC_PEEK, $urandom_range(0, 63));
			end else begin
				add_op(FUNC_CLEAR, $urandom_range(0, 63));
			end
		end
		planned_cnt = backlog.size();
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (sent_cnt != planned_cnt || replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && replies.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.data <= '0;
			sent_cnt <= 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				stack_apply(cmd_ch.data);
				sent_cnt <= sent_cnt + 1;
			end
			// hold the offered transaction until accepted
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					cmd_ch.valid <= 1'b1;
					cmd_ch.data <= backlog.pop_front();
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && sent_cnt >= random_start + 20) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (replies.size() == 0) begin
					$error("response transaction with nothing pending");
					mismatches++;
				end else begin
					reply_head = replies.pop_front();
					check_field("ok", reply_head.ok, rsp_ch.data.ok);
					check_field("byte_valid", reply_head.byte_valid, rsp_ch.data.byte_valid);
					check_field("data_out", reply_head.data_out, rsp_ch.data.data_out);
					check_field("last", reply_head.last, rsp_ch.data.last);
					check_field("empty_res", reply_head.empty_res, rsp_ch.data.empty_res);
					check_field("free_bytes", reply_head.free_bytes, rsp_ch.data.free_bytes);
				end
			end
			rsp_ch.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

endmodule
